FILE: rtl/core/argb_unp_pkg.sv
// ============================================================================
// ARGB unpremultiply package
// Types, constants and the shared divide step for the unpremultiply unit.
// ============================================================================
package argb_unp_pkg;

    // Fixed widths and constants of the pixel format.
    localparam int unsigned   CH_W       = 8;
    localparam int unsigned   NUM_LANES  = 3;
    localparam int unsigned   DIV_STEPS  = CH_W;
    localparam logic [7:0]    FULL_ALPHA = 8'hFF;
    localparam logic [23:0]   BG_RESET   = 24'hFFFFFF;

    // Register indexes of the configuration port.
    localparam logic          REG_BACKGROUND = 1'b0;

    // One input beat.
    typedef struct packed {
        logic [7:0] alpha_in;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       last_in;
    } t_in_item;

    // One output beat.
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_out;
    } t_out_item;

    // Pixel classes by alpha.
    typedef enum logic [1:0] {
        PIX_OPAQUE,
        PIX_CLEAR,
        PIX_BLEND
    } t_pix_class;

    // One color lane on its way through the divider. When div is low the
    // bits field already holds the final channel value. When div is high,
    // rem holds the partial remainder and bits holds the dividend bits not
    // yet consumed, with quotient bits shifting in from the bottom.
    typedef struct packed {
        logic       div;
        logic [7:0] rem;
        logic [7:0] bits;
    } t_lane;

    // One classified pixel as it sits in the queue and the divider.
    typedef struct packed {
        logic                         last;
        logic [7:0]                   alpha;
        t_lane [NUM_LANES-1:0]        lanes;
    } t_entry;

    // One restoring division step: brings down one dividend bit and
    // produces one quotient bit.
    function automatic t_lane div_step(input t_lane l, input logic [7:0] d);
        logic [8:0] trial;
        t_lane      r;
        r     = l;
        trial = {l.rem, l.bits[7]};
        if (l.div) begin
            if (trial >= {1'b0, d}) begin
                r.rem  = 8'(trial - {1'b0, d});
                r.bits = {l.bits[6:0], 1'b1};
            end else begin
                r.rem  = trial[7:0];
                r.bits = {l.bits[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/argb_unp_front.sv
// ============================================================================
// ARGB unpremultiply front end
// Accepts input beats and classifies each pixel by alpha into a queue entry.
// ============================================================================
module argb_unp_front
    import argb_unp_pkg::*;
(
    input  logic        i_valid,
    input  t_in_item    i_item,
    input  logic [23:0] i_background,
    input  logic        i_queue_full,
    output logic        o_stall,
    output logic        o_push,
    output t_entry      o_entry
);

    t_pix_class             w_class;
    logic [7:0]             w_chan [NUM_LANES];
    logic [7:0]             w_bg   [NUM_LANES];
    logic [15:0]            w_prod [NUM_LANES];

    // A beat is taken whenever the queue has room.
    assign o_stall = i_queue_full;
    assign o_push  = i_valid & ~i_queue_full;

    // Lane order: index 2 is red, 1 is green, 0 is blue.
    assign w_chan[2] = i_item.red_in;
    assign w_chan[1] = i_item.green_in;
    assign w_chan[0] = i_item.blue_in;
    assign w_bg[2]   = i_background[23:16];
    assign w_bg[1]   = i_background[15:8];
    assign w_bg[0]   = i_background[7:0];

    // Classify the pixel by its alpha.
    always_comb begin
        if (i_item.alpha_in == FULL_ALPHA) begin
            w_class = PIX_OPAQUE;
        end else if (i_item.alpha_in == '0) begin
            w_class = PIX_CLEAR;
        end else begin
            w_class = PIX_BLEND;
        end
    end

    // Build each lane: pass-through, background, saturation or a division
    // of 255 * c by alpha. In a blend, a channel at or above alpha saturates.
    always_comb begin
        o_entry.last  = i_item.last_in;
        o_entry.alpha = i_item.alpha_in;
        for (int i = 0; i < NUM_LANES; i++) begin
            w_prod[i] = {w_chan[i], 8'h00} - {8'h00, w_chan[i]};
            o_entry.lanes[i].div  = 1'b0;
            o_entry.lanes[i].rem  = '0;
            o_entry.lanes[i].bits = w_chan[i];
            case (w_class)
                PIX_OPAQUE: begin
                    o_entry.lanes[i].bits = w_chan[i];
                end
                PIX_CLEAR: begin
                    o_entry.lanes[i].bits = w_bg[i];
                end
                PIX_BLEND: begin
                    if (w_chan[i] >= i_item.alpha_in) begin
                        o_entry.lanes[i].bits = FULL_ALPHA;
                    end else begin
                        o_entry.lanes[i].div  = 1'b1;
                        o_entry.lanes[i].rem  = w_prod[i][15:8];
                        o_entry.lanes[i].bits = w_prod[i][7:0];
                    end
                end
                default: begin
                    o_entry.lanes[i].bits = w_chan[i];
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/argb_unp_queue.sv
// ============================================================================
// ARGB unpremultiply queue
// Short register queue that decouples the front end from the divider.
// ============================================================================
module argb_unp_queue
    import argb_unp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_entry                     i_entry,
    input  logic                       i_pop,
    output t_entry                     o_head,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry         r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and count update with explicit wrap.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CW'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: rtl/core/argb_unp_back.sv
// ============================================================================
// ARGB unpremultiply back end
// Pipelined restoring divider, one quotient bit per stage, and output register.
// ============================================================================
module argb_unp_back
    import argb_unp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic       r_vld [DIV_STEPS];
    t_entry     r_stg [DIV_STEPS];
    t_entry     w_stg_in [DIV_STEPS];
    logic       w_vld_in [DIV_STEPS];
    logic       w_adv;
    logic       r_out_vld;
    t_out_item  r_out;

    // The whole pipeline moves whenever the output register can take a beat.
    assign w_adv = ~r_out_vld | ~i_out_stall;
    assign o_pop = w_adv & ~i_empty;

    // Each stage applies one division step to all three lanes.
    always_comb begin
        for (int s = 0; s < DIV_STEPS; s++) begin
            if (s == 0) begin
                w_stg_in[s] = i_head;
                w_vld_in[s] = ~i_empty;
            end else begin
                w_stg_in[s] = r_stg[s-1];
                w_vld_in[s] = r_vld[s-1];
            end
            for (int l = 0; l < NUM_LANES; l++) begin
                w_stg_in[s].lanes[l] = div_step(w_stg_in[s].lanes[l], w_stg_in[s].alpha);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_vld[s] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_vld[s] <= w_vld_in[s];
            end
            r_out_vld <= r_vld[DIV_STEPS-1];
        end
    end

    // Stage payloads and the output beat.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_stg[s] <= w_stg_in[s];
            end
            r_out.red_out   <= r_stg[DIV_STEPS-1].lanes[2].bits;
            r_out.green_out <= r_stg[DIV_STEPS-1].lanes[1].bits;
            r_out.blue_out  <= r_stg[DIV_STEPS-1].lanes[0].bits;
            r_out.alpha_out <= FULL_ALPHA;
            r_out.last_out  <= r_stg[DIV_STEPS-1].last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/core/argb_unpremultiply_to_rgba_unit.sv
// ============================================================================
// ARGB unpremultiply to RGBA unit
// Converts premultiplied ARGB8888 pixels to opaque RGBA8888 pixels.
// ============================================================================
// The unit takes one pixel beat per clock and gives one result beat per clock
// in steady state while the output is not stalled. Each pixel is classified
// as it enters a small queue (QUEUE_DEPTH entries), then passes through the
// divider pipeline that forms floor(255 * c / alpha) one quotient bit per
// stage for all three color channels, then through the output register.
// Fully opaque pixels pass their colors, fully transparent pixels take the
// background register, and in other pixels channels at or above alpha
// saturate at 255. Output alpha is always 255 and the last marker follows
// its pixel. The input stalls only when the queue is full.
module argb_unpremultiply_to_rgba_unit
    import argb_unp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Pixel input.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // Pixel output.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0]                      r_background;
    logic                             w_cfg_wr;
    logic                             w_push;
    logic                             w_pop;
    t_entry                           w_entry;
    t_entry                           w_head;
    logic                             w_empty;
    logic                             w_full;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] w_count;

    // Background register, word-addressed.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & (paddr[2] == REG_BACKGROUND);
    assign prdata   = (paddr[2] == REG_BACKGROUND) ? {8'h00, r_background} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_background <= BG_RESET;
        end else if (w_cfg_wr) begin
            r_background <= pwdata[23:0];
        end
    end

    // Front end: accept and classify.
    argb_unp_front u_front (
        .i_valid      (i_in_valid),
        .i_item       (i_in_data),
        .i_background (r_background),
        .i_queue_full (w_full),
        .o_stall      (o_in_stall),
        .o_push       (w_push),
        .o_entry      (w_entry)
    );

    // Queue between front and back.
    argb_unp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_count (w_count)
    );

    // Back end: divide and deliver.
    argb_unp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Every delivered pixel is opaque.
    a_out_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.alpha_out == FULL_ALPHA))
        else $error("output pixel is not opaque");

    // The queue never holds more than its depth.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // The input can only start stalling after a beat went into the queue.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(w_push))
        else $error("input stall rose without a push");

endmodule

FILE: tb/sv/tb_argb_unpremultiply_to_rgba_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the ARGB unpremultiply to RGBA unit
// Sends premultiplied ARGB pixels through the unit under random input gaps
// and output stalls. A local predictor computes each expected RGBA pixel as
// the input beat is accepted. The monitor compares every output beat, field
// by field, with the oldest prediction. The background register is rewritten
// between phases, only while the unit is drained.
// ============================================================================
module tb_argb_unpremultiply_to_rgba_unit;
    import argb_unp_pkg::*;

    // Run control.
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned IDLE_LIMIT   = 1000;
    localparam int unsigned PHASE_PIXELS = 110;

    // Register byte addresses.
    localparam logic [2:0] ADDR_BACKGROUND = {REG_BACKGROUND, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED   = {~REG_BACKGROUND, 2'b00};

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    in_data   = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_data;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and prediction state.
    t_in_item    argb_pending[$];
    t_out_item   rgba_expected[$];
    logic [23:0] background_shadow = BG_RESET;
    bit          calm_phase = 1'b0;
    int unsigned error_count = 0;
    int unsigned pixels_checked = 0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned idle_cycles = 0;

    wire in_fire  = in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !out_stall;

    argb_unpremultiply_to_rgba_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Divides one premultiplied channel back out, saturating at full scale.
    function automatic logic [7:0] scale_channel(input logic [7:0] c, input logic [7:0] a);
        int unsigned q;
        q = (int'(FULL_ALPHA) * int'(c)) / int'(a);
        return (q > int'(FULL_ALPHA)) ? FULL_ALPHA : 8'(q);
    endfunction

    // Expected opaque pixel for one input pixel under the given background.
    function automatic t_out_item unpremultiply_pixel(input t_in_item p,
                                                      input logic [23:0] bg);
        t_out_item o;
        o.alpha_out = FULL_ALPHA;
        o.last_out  = p.last_in;
        if (p.alpha_in == FULL_ALPHA) begin
            o.red_out   = p.red_in;
            o.green_out = p.green_in;
            o.blue_out  = p.blue_in;
        end else if (p.alpha_in == 8'h00) begin
            {o.red_out, o.green_out, o.blue_out} = bg;
        end else begin
            o.red_out   = scale_channel(p.red_in, p.alpha_in);
            o.green_out = scale_channel(p.green_in, p.alpha_in);
            o.blue_out  = scale_channel(p.blue_in, p.alpha_in);
        end
        return o;
    endfunction

    // Mostly short delays, now and then a long one; none in a calm phase.
    function automatic int unsigned pick_delay();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (calm_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Random pixel: mostly well-formed blends, plus opaque, clear and
    // malformed pixels whose channels may exceed alpha.
    function automatic t_in_item random_pixel();
        t_in_item    p;
        int unsigned kind;
        kind       = $urandom_range(99, 0);
        p.red_in   = 8'($urandom);
        p.green_in = 8'($urandom);
        p.blue_in  = 8'($urandom);
        p.last_in  = ($urandom_range(7, 0) == 0);
        if (kind < 10) begin
            p.alpha_in = 8'h00;
        end else if (kind < 25) begin
            p.alpha_in = FULL_ALPHA;
        end else begin
            p.alpha_in = 8'($urandom_range(254, 1));
            if (kind < 80) begin
                p.red_in   = 8'($urandom_range(p.alpha_in, 0));
                p.green_in = 8'($urandom_range(p.alpha_in, 0));
                p.blue_in  = 8'($urandom_range(p.alpha_in, 0));
            end
        end
        return p;
    endfunction

    task automatic add_pixel(input logic [7:0] a, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic last);
        t_in_item p;
        p.alpha_in = a;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        p.last_in  = last;
        argb_pending.push_back(p);
    endtask

    task automatic add_random_pixels(input int unsigned n);
        repeat (n) argb_pending.push_back(random_pixel());
    endtask

    // Waits until every pixel is sent and every result has come back.
    task automatic wait_drained();
        while (argb_pending.size() != 0 || in_valid || rgba_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BACKGROUND)
            background_shadow = data[23:0];
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] pixel %0d: %s is 0x%02h, expected 0x%02h",
                 $time, pixels_checked, field, got, want);
        error_count++;
    endtask

    // Input driver: predicts each accepted beat, then loads the next pixel
    // once the current one is gone and the random gap has run out.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_fire)
                rgba_expected.push_back(unpremultiply_pixel(in_data, background_shadow));
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (argb_pending.size() != 0) begin
                    in_data  <= argb_pending.pop_front();
                    in_valid <= 1'b1;
                    gap_left = pick_delay();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted beat and drives random stalls.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (out_fire) begin
                if (rgba_expected.size() == 0) begin
                    $display("[%0t] output beat with no pixel outstanding", $time);
                    error_count++;
                end else begin
                    want = rgba_expected.pop_front();
                    if (o_out_data.red_out !== want.red_out)
                        report_mismatch("red", o_out_data.red_out, want.red_out);
                    if (o_out_data.green_out !== want.green_out)
                        report_mismatch("green", o_out_data.green_out, want.green_out);
                    if (o_out_data.blue_out !== want.blue_out)
                        report_mismatch("blue", o_out_data.blue_out, want.blue_out);
                    if (o_out_data.alpha_out !== want.alpha_out)
                        report_mismatch("alpha", o_out_data.alpha_out, want.alpha_out);
                    if (o_out_data.last_out !== want.last_out)
                        report_mismatch("last", 8'(o_out_data.last_out), 8'(want.last_out));
                    pixels_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                stall_left = pick_delay();
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout, %0d pixels outstanding", $time, rgba_expected.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels under the reset background.
        add_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);      // opaque, black
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);      // opaque, white
        add_pixel(8'hFF, 8'h12, 8'hA5, 8'h5A, 1'b0);      // opaque passes as is
        add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);      // clear takes background
        add_pixel(8'h00, 8'hFF, 8'h80, 8'h01, 1'b1);      // clear ignores channels
        add_pixel(8'h01, 8'h00, 8'h01, 8'hFF, 1'b0);      // smallest alpha
        add_pixel(8'hFE, 8'hFE, 8'hFD, 8'h00, 1'b0);      // largest blend alpha
        add_pixel(8'hFE, 8'hFF, 8'h01, 8'h7F, 1'b1);
        add_pixel(8'h80, 8'h40, 8'h7F, 8'h80, 1'b0);
        add_pixel(8'h64, 8'hC8, 8'h65, 8'hFF, 1'b0);      // channels above alpha saturate
        add_pixel(8'h7F, 8'h7E, 8'h01, 8'h80, 1'b1);
        add_pixel(8'h03, 8'h02, 8'h03, 8'h04, 1'b0);
        add_pixel(8'hAA, 8'h55, 8'hAA, 8'hAB, 1'b0);
        add_pixel(8'h55, 8'h2A, 8'h54, 8'h55, 1'b1);
        wait_drained();

        // Black background: clear pixels at the low extreme.
        write_reg(ADDR_BACKGROUND, {8'($urandom), 24'h000000});
        add_pixel(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        add_pixel(8'h00, 8'h12, 8'h34, 8'h56, 1'b0);
        add_random_pixels(60);
        wait_drained();

        // A write past the last register changes nothing.
        write_reg(ADDR_UNMAPPED, $urandom);
        add_pixel(8'h00, 8'hAB, 8'hCD, 8'hEF, 1'b0);
        add_random_pixels(60);
        wait_drained();

        // Random phases, white background first, one phase with no idling.
        for (int unsigned phase = 0; phase < 5; phase++) begin
            calm_phase = (phase == 2);
            if (phase == 0)
                write_reg(ADDR_BACKGROUND, {8'($urandom), 24'hFFFFFF});
            else
                write_reg(ADDR_BACKGROUND, $urandom);
            add_random_pixels(PHASE_PIXELS);
            wait_drained();
        end

        if (error_count == 0 && rgba_expected.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/argb_unp_pkg.sv
rtl/core/argb_unp_front.sv
rtl/core/argb_unp_queue.sv
rtl/core/argb_unp_back.sv
rtl/core/argb_unpremultiply_to_rgba_unit.sv
tb/sv/tb_argb_unpremultiply_to_rgba_unit.sv
